// ===== rtl/acpr_pkg.sv =====
// Package with the shared types, codes and helpers of the ARP cache block.
`default_nettype none
package acpr_pkg;

    localparam int MAX_RES = 8;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_APPEND = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_LOOKUP  = 3'd0,
        K_QUEUED  = 3'd1,
        K_SEND    = 3'd2,
        K_RELEASE = 3'd3,
        K_UNREACH = 3'd4,
        K_NOTHING = 3'd5,
        K_FULL    = 3'd6
    } t_kind;

    localparam logic REG_ENTRY_TIMEOUT = 1'b0;
    localparam logic REG_MAX_RETRIES   = 1'b1;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] added;
    } t_centry;

    typedef struct packed {
        logic [31:0] ip;
        logic [3:0]  iface;
        logic [2:0]  retries;
        logic [15:0] sent;
    } t_pentry;

    typedef struct packed {
        t_kind       kind;
        logic        hit;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [3:0]  iface;
        logic [2:0]  slot;
    } t_res;

    function automatic t_res mk_res(t_kind kind, logic hit, logic [47:0] mac,
                                    logic [31:0] ip, logic [3:0] iface,
                                    logic [2:0] slot);
        t_res r;
        r.kind  = kind;
        r.hit   = hit;
        r.mac   = mac;
        r.ip    = ip;
        r.iface = iface;
        r.slot  = slot;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/arp_cache_with_pending_requests_core.sv =====
// Top level of the ARP cache with pending requests: sequencer, valid bits and result register.
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_ready, op/ip/mac/iface   | to block
//  out     | o_out_valid, i_out_ready, result fields   | from block
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_wdata          | to block
//
// An operation reads each valid cache entry or pending slot it visits through the single read
// port of a memory and steps over each invalid one. It accepts the beat, runs its scans,
// pushes each result beat other than a nothing beat, closes each scan that runs to its end
// or to the result limit, and then presents the final beat. A beat is accepted only when idle.
// Reset is synchronous and clears all valid bits and the time counter at once.
// A stalled output holds the sequencer in its push or finish state.
`default_nettype none
module arp_cache_with_pending_requests_core #(
    parameter int CACHE_ENTRIES = 16,
    parameter int PENDING_SLOTS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_ip_addr,
    input  wire logic [47:0] i_mac_addr,
    input  wire logic [3:0]  i_iface_id,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_kind,
    output logic             o_hit,
    output logic [47:0]      o_mac_out,
    output logic [31:0]      o_ip_out,
    output logic [3:0]       o_iface_out,
    output logic [2:0]       o_slot,
    output logic             o_last,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_wdata
);
    import acpr_pkg::*;

    localparam int CW  = $clog2(CACHE_ENTRIES);
    localparam int CIW = $clog2(CACHE_ENTRIES + 1);
    localparam int PW  = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int PIW = $clog2(PENDING_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CRD, S_CCMP, S_PRD, S_PCMP, S_PUSH, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic [CIW-1:0] r_cidx, n_cidx;
    logic [PIW-1:0] r_pidx, n_pidx;
    logic [CACHE_ENTRIES-1:0] r_cvalid, n_cvalid;
    logic [PENDING_SLOTS-1:0] r_pvalid, n_pvalid;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_now, n_now;
    logic [CW-1:0] r_mod, n_mod;
    t_op         r_op, n_op;
    logic [31:0] r_ip, n_ip;
    logic [47:0] r_mac, n_mac;
    logic [3:0]  r_iface, n_iface;
    t_res        r_hold, n_hold, r_new, n_new, r_out, n_out;
    logic        r_hold_v, n_hold_v, r_fin, n_fin;
    logic        r_out_v, n_out_v, r_out_last, n_out_last;
    logic [7:0]  r_tmo;
    logic [2:0]  r_maxr;

    logic            c_we, c_re;
    logic [CW-1:0]   c_waddr, c_raddr;
    t_centry         c_wdata, c_rdata;
    logic            p_we, p_re;
    logic [PW-1:0]   p_waddr, p_raddr;
    t_pentry         p_wdata, p_rdata;

    logic            c_free_v, p_free_v, out_free;
    logic [CW-1:0]   c_free;
    logic [PW-1:0]   p_free;
    logic [15:0]     age, elapsed;
    logic [2:0]      slot_now;

    acpr_cache_ram #(.DEPTH(CACHE_ENTRIES), .AW(CW)) u_cache (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_re(c_re), .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    acpr_pend_ram #(.DEPTH(PENDING_SLOTS), .AW(PW)) u_pend (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_re(p_re), .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    always_comb begin
        c_free_v = 1'b0;
        c_free   = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_cvalid[i]) begin
                c_free_v = 1'b1;
                c_free   = CW'(i);
            end
        end
        p_free_v = 1'b0;
        p_free   = '0;
        for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
            if (!r_pvalid[i]) begin
                p_free_v = 1'b1;
                p_free   = PW'(i);
            end
        end
    end

    assign out_free   = !r_out_v || i_out_ready;
    assign age        = r_now - c_rdata.added;
    assign elapsed    = r_now - p_rdata.sent;
    assign slot_now   = 3'(r_pidx);
    assign c_raddr    = r_cidx[CW-1:0];
    assign p_raddr    = r_pidx[PW-1:0];
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_cidx     = r_cidx;
        n_pidx     = r_pidx;
        n_cvalid   = r_cvalid;
        n_pvalid   = r_pvalid;
        n_cnt      = r_cnt;
        n_now      = r_now;
        n_mod      = r_mod;
        n_op       = r_op;
        n_ip       = r_ip;
        n_mac      = r_mac;
        n_iface    = r_iface;
        n_hold     = r_hold;
        n_hold_v   = r_hold_v;
        n_new      = r_new;
        n_fin      = r_fin;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_v    = r_out_v && !i_out_ready;
        c_we       = 1'b0;
        c_re       = 1'b0;
        c_waddr    = c_free_v ? c_free : r_mod;
        c_wdata    = '{ip: i_ip_addr, mac: i_mac_addr, added: r_now};
        p_we       = 1'b0;
        p_re       = 1'b0;
        p_waddr    = p_free;
        p_wdata    = '{ip: r_ip, iface: r_iface, retries: 3'd0, sent: r_now};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = t_op'(i_op);
                    n_ip    = i_ip_addr;
                    n_mac   = i_mac_addr;
                    n_iface = i_iface_id;
                    n_cnt   = '0;
                    n_cidx  = '0;
                    n_pidx  = '0;
                    unique case (t_op'(i_op))
                        OP_LOOKUP: n_state = S_CRD;
                        OP_INSERT: begin
                            c_we = 1'b1;
                            n_cvalid[c_waddr] = 1'b1;
                            n_state = S_PRD;
                        end
                        OP_APPEND: n_state = S_PRD;
                        OP_TICK: begin
                            n_now = r_now + 16'd1;
                            if (r_now == 16'hFFFF || r_mod == CW'(CACHE_ENTRIES - 1)) begin
                                n_mod = '0;
                            end else begin
                                n_mod = r_mod + CW'(1);
                            end
                            n_state = S_CRD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CRD: begin
                if (r_cidx == CIW'(CACHE_ENTRIES)) begin
                    if (r_op == OP_LOOKUP) begin
                        n_new   = mk_res(K_LOOKUP, 1'b0, '0, r_ip, '0, '0);
                        n_fin   = 1'b1;
                        n_cnt   = r_cnt + 4'd1;
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_PRD;
                    end
                end else if (!r_cvalid[r_cidx[CW-1:0]]) begin
                    n_cidx = r_cidx + CIW'(1);
                end else begin
                    c_re    = 1'b1;
                    n_state = S_CCMP;
                end
            end
            S_CCMP: begin
                n_cidx  = r_cidx + CIW'(1);
                n_state = S_CRD;
                if (r_op == OP_LOOKUP) begin
                    if (c_rdata.ip == r_ip) begin
                        n_new   = mk_res(K_LOOKUP, 1'b1, c_rdata.mac, r_ip, '0, '0);
                        n_fin   = 1'b1;
                        n_cnt   = r_cnt + 4'd1;
                        n_state = S_PUSH;
                    end
                end else if (age > {8'd0, r_tmo}) begin
                    n_cvalid[r_cidx[CW-1:0]] = 1'b0;
                end
            end
            S_PRD: begin
                if (r_pidx == PIW'(PENDING_SLOTS) || r_cnt == 4'(MAX_RES)) begin
                    if (r_op == OP_APPEND) begin
                        n_fin   = 1'b1;
                        n_cnt   = r_cnt + 4'd1;
                        n_state = S_PUSH;
                        if (p_free_v) begin
                            p_we = 1'b1;
                            n_pvalid[p_free] = 1'b1;
                            n_new = mk_res(K_SEND, 1'b0, '0, r_ip, r_iface, 3'(p_free));
                        end else begin
                            n_new = mk_res(K_FULL, 1'b0, '0, r_ip, r_iface, '0);
                        end
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (!r_pvalid[r_pidx[PW-1:0]]) begin
                    n_pidx = r_pidx + PIW'(1);
                end else begin
                    p_re    = 1'b1;
                    n_state = S_PCMP;
                end
            end
            S_PCMP: begin
                n_pidx  = r_pidx + PIW'(1);
                n_state = S_PRD;
                n_fin   = 1'b0;
                priority if (r_op == OP_INSERT) begin
                    if (p_rdata.ip == r_ip) begin
                        n_new   = mk_res(K_RELEASE, 1'b0, r_mac, r_ip, p_rdata.iface, slot_now);
                        n_cnt   = r_cnt + 4'd1;
                        n_state = S_PUSH;
                        n_pvalid[r_pidx[PW-1:0]] = 1'b0;
                    end
                end else if (r_op == OP_APPEND) begin
                    if (p_rdata.ip == r_ip && p_rdata.iface == r_iface) begin
                        n_new   = mk_res(K_QUEUED, 1'b0, '0, r_ip, r_iface, slot_now);
                        n_fin   = 1'b1;
                        n_cnt   = r_cnt + 4'd1;
                        n_state = S_PUSH;
                    end
                end else begin
                    if (p_rdata.retries < r_maxr) begin
                        if (elapsed != 16'd0) begin
                            p_we    = 1'b1;
                            p_waddr = r_pidx[PW-1:0];
                            p_wdata = '{ip: p_rdata.ip, iface: p_rdata.iface,
                                        retries: p_rdata.retries + 3'd1, sent: r_now};
                            n_new   = mk_res(K_SEND, 1'b0, '0, p_rdata.ip, p_rdata.iface,
                                             slot_now);
                            n_cnt   = r_cnt + 4'd1;
                            n_state = S_PUSH;
                        end
                    end else begin
                        n_new   = mk_res(K_UNREACH, 1'b0, '0, p_rdata.ip, p_rdata.iface,
                                         slot_now);
                        n_cnt   = r_cnt + 4'd1;
                        n_state = S_PUSH;
                        n_pvalid[r_pidx[PW-1:0]] = 1'b0;
                    end
                end
            end
            S_PUSH: begin
                if (!r_hold_v) begin
                    n_hold   = r_new;
                    n_hold_v = 1'b1;
                    n_state  = r_fin ? S_FIN : S_PRD;
                end else if (out_free) begin
                    n_out      = r_hold;
                    n_out_last = 1'b0;
                    n_out_v    = 1'b1;
                    n_hold     = r_new;
                    n_state    = r_fin ? S_FIN : S_PRD;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out      = r_hold_v ? r_hold : mk_res(K_NOTHING, 1'b0, '0, '0, '0, '0);
                    n_out_last = 1'b1;
                    n_out_v    = 1'b1;
                    n_hold_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cvalid <= '0;
            r_pvalid <= '0;
            r_now    <= '0;
            r_mod    <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_cnt    <= '0;
            r_tmo    <= 8'd15;
            r_maxr   <= 3'd5;
        end else begin
            r_state  <= n_state;
            r_cvalid <= n_cvalid;
            r_pvalid <= n_pvalid;
            r_now    <= n_now;
            r_mod    <= n_mod;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
            r_cnt    <= n_cnt;
            if (i_cfg_we) begin
                unique case (i_cfg_idx[0])
                    REG_ENTRY_TIMEOUT: r_tmo  <= i_cfg_wdata;
                    REG_MAX_RETRIES:   r_maxr <= i_cfg_wdata[2:0];
                    default:           r_tmo  <= r_tmo;
                endcase
            end
        end
        r_cidx     <= n_cidx;
        r_pidx     <= n_pidx;
        r_op       <= n_op;
        r_ip       <= n_ip;
        r_mac      <= n_mac;
        r_iface    <= n_iface;
        r_hold     <= n_hold;
        r_new      <= n_new;
        r_fin      <= n_fin;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_v;
    assign o_kind      = r_out.kind;
    assign o_hit       = r_out.hit;
    assign o_mac_out   = r_out.mac;
    assign o_ip_out    = r_out.ip;
    assign o_iface_out = r_out.iface;
    assign o_slot      = r_out.slot;
    assign o_last      = r_out_last;

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("Held result left over while idle.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Second beat accepted while an operation runs.");

    a_result_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(MAX_RES))
        else $error("Too many results for one operation.");

    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (o_out_valid && o_last))
        else $error("Finish did not present the final beat.");
endmodule
`default_nettype wire

// ===== rtl/acpr_cache_ram.sv =====
// Synchronous memory holding the address, MAC and insertion time of each cache entry.
`default_nettype none
module acpr_cache_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire acpr_pkg::t_centry i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output acpr_pkg::t_centry     o_rdata
);
    import acpr_pkg::*;

    t_centry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/acpr_pend_ram.sv =====
// Synchronous memory holding the address, interface, retry count and send time of each pending slot.
`default_nettype none
module acpr_pend_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire acpr_pkg::t_pentry i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output acpr_pkg::t_pentry     o_rdata
);
    import acpr_pkg::*;

    t_pentry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire
